@@ sv/heap_sift_down_by_name_top_assert.svh @@
// Assertion macros used by the RTL of the heap sift block.
// Each macro takes a label, the clock, the active-low reset, a condition,
// a consequence and a message string.
`ifndef HEAP_SIFT_DOWN_BY_NAME_TOP_ASSERT_SVH
`define HEAP_SIFT_DOWN_BY_NAME_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define HSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the condition.
`define HSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hsd_pkg.sv @@
`default_nettype none

package hsd_pkg;

  localparam int SLOT_W = 8;
  localparam int NAME_W = 64;
  localparam int PAY_W  = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SIFT  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

`default_nettype wire

@@ sv/hsd_in_if.sv @@
`default_nettype none

// Request channel: one item per write, read or sift command.
interface hsd_in_if import hsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] heap_last;
  logic [NAME_W-1:0] name_key;
  logic [PAY_W-1:0]  payload_handle;

  modport source (
    output valid, opcode, slot, heap_last, name_key, payload_handle,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot, heap_last, name_key, payload_handle,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/hsd_out_if.sv @@
`default_nettype none

// Result channel: exactly one item per accepted request.
interface hsd_out_if import hsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NAME_W-1:0] read_name;
  logic [PAY_W-1:0]  read_payload;
  logic [SLOT_W-1:0] settled_slot;
  logic              status;

  modport source (
    output valid, read_name, read_payload, settled_slot, status,
    input  ready
  );
  modport sink (
    input  valid, read_name, read_payload, settled_slot, status,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/heap_sift_down_by_name_top.sv @@
// Heap store with binary max-heap sift-down on fixed-length name keys.
// Requests arrive on in_chan (valid/ready); each accepted item is a slot
// write, a slot read or a sift of the entry at a root slot down to heap_last.
// Exactly one result item leaves on out_chan (valid/ready) for every request.
// A write, a bad slot or an unused opcode goes from idle straight to the
// emit state, and a read passes through S_RDATA first. A sift loads the root
// entry in S_ROOT and walks down the heap level by level: a pick step (S_PICK)
// reads both children and picks the larger, and a move step (S_MOVE) compares
// it with the carried entry and writes the moved child back. It stops on a
// compare, at a root with no child, or in S_FINAL when the last move reaches
// the bottom of the heap, where the carried entry is written into the hole.
// A new request is taken only in idle, once the result is in the output
// register; with a ready receiver it is taken at the same edge at which
// that result is taken.
// A finished result sits in an output register, so the next request is taken
// while the receiver stalls; only the hand-off of the following result waits.
// Synchronous reset (rst_n low) empties the output register and returns to
// idle; the entry memory is not cleared and a slot must be written before
// it is read or sifted.

`default_nettype none

`include "heap_sift_down_by_name_top_assert.svh"

module heap_sift_down_by_name_top import hsd_pkg::*; #(
  parameter int DEPTH        = 255,
  parameter int NAME_BYTES   = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  hsd_in_if.sink   in_chan,
  hsd_out_if.source out_chan
);

  // Slots are 8-bit fields, so at most 255 of them are addressable.
  localparam int MAX_SLOT = (DEPTH < 255) ? DEPTH : 255;
  localparam int AW       = $clog2(MAX_SLOT + 1);
  localparam int NW       = NAME_BYTES * 8;
  localparam int PW       = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int EW       = NW + PW;
  localparam logic [SLOT_W-1:0] MAX_SLOT_V = SLOT_W'(MAX_SLOT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_ROOT,
    S_PICK,
    S_MOVE,
    S_FINAL,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [SLOT_W-1:0] hole_r;
  logic [SLOT_W-1:0] kid_r;
  logic [SLOT_W-1:0] last_r;
  logic [EW-1:0]     carry_r;
  logic [EW-1:0]     child_r;

  // Result being assembled, and the output register that holds it for the sink.
  logic [NW-1:0]     res_name_r;
  logic [PW-1:0]     res_pay_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_status_r;
  logic              out_valid_r;
  logic [NW-1:0]     out_name_r;
  logic [PW-1:0]     out_pay_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_status_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [EW-1:0] rd_a;
  logic [EW-1:0] rd_b;

  logic        accept;
  opcode_t     op;
  logic        slot_ok;
  logic        last_ok;
  logic [SLOT_W:0] left_root;
  logic [SLOT_W:0] right_root;
  logic [SLOT_W:0] left_move;
  logic [SLOT_W:0] right_move;
  logic        root_leaf;
  logic        deeper_ok;
  logic        pick_right;
  logic        carry_less;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign op            = opcode_t'(in_chan.opcode);
  assign slot_ok       = (in_chan.slot != '0) && (in_chan.slot <= MAX_SLOT_V);
  assign last_ok       = (in_chan.heap_last != '0) && (in_chan.heap_last <= MAX_SLOT_V);

  // Children of the current hole: 2h and 2h+1, nine bits wide so that an
  // overflow past the heap end is seen rather than wrapped.
  assign left_root  = {hole_r, 1'b0};
  assign right_root = {hole_r, 1'b1};
  assign left_move  = {kid_r, 1'b0};
  assign right_move = {kid_r, 1'b1};
  assign root_leaf  = left_root > {1'b0, last_r};
  assign deeper_ok  = left_move <= {1'b0, last_r};

  // The right child wins only when it exists and is strictly larger.
  assign pick_right = (kid_r < last_r) && (rd_b[EW-1:PW] > rd_a[EW-1:PW]);
  assign carry_less = carry_r[EW-1:PW] < child_r[EW-1:PW];

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = hole_r[AW-1:0];
    mem_wdata   = carry_r;
    mem_raddr_a = in_chan.slot[AW-1:0];
    mem_raddr_b = right_root[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept && (op == OP_WRITE) && slot_ok) begin
          mem_we    = 1'b1;
          mem_waddr = in_chan.slot[AW-1:0];
          mem_wdata = {in_chan.name_key[NW-1:0], in_chan.payload_handle[PW-1:0]};
        end
      end
      S_ROOT: begin
        mem_raddr_a = left_root[AW-1:0];
        mem_raddr_b = right_root[AW-1:0];
      end
      S_MOVE: begin
        // Grandchildren are fetched while the child moves up; they lie
        // below the hole, so the write never meets these reads.
        mem_we      = 1'b1;
        mem_wdata   = carry_less ? child_r : carry_r;
        mem_raddr_a = left_move[AW-1:0];
        mem_raddr_b = right_move[AW-1:0];
      end
      S_FINAL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  hsd_store #(
    .AW (AW),
    .EW (EW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_name_r   <= '0;
            res_pay_r    <= '0;
            res_slot_r   <= '0;
            res_status_r <= STATUS_OK;
            hole_r       <= in_chan.slot;
            last_r       <= in_chan.heap_last;
            state_r      <= S_EMIT;
            case (op)
              OP_WRITE: begin
                if (!slot_ok) begin
                  res_status_r <= STATUS_RANGE;
                end
              end
              OP_READ: begin
                if (slot_ok) begin
                  state_r <= S_RDATA;
                end else begin
                  res_status_r <= STATUS_RANGE;
                end
              end
              OP_SIFT: begin
                if (slot_ok && last_ok) begin
                  state_r <= S_ROOT;
                end else begin
                  res_status_r <= STATUS_RANGE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RDATA: begin
          res_name_r <= rd_a[EW-1:PW];
          res_pay_r  <= rd_a[PW-1:0];
          state_r    <= S_EMIT;
        end
        S_ROOT: begin
          carry_r <= rd_a;
          kid_r   <= left_root[SLOT_W-1:0];
          if (root_leaf) begin
            res_slot_r <= hole_r;
            state_r    <= S_EMIT;
          end else begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          child_r <= pick_right ? rd_b : rd_a;
          kid_r   <= pick_right ? {kid_r[SLOT_W-1:1], 1'b1} : kid_r;
          state_r <= S_MOVE;
        end
        S_MOVE: begin
          if (carry_less) begin
            hole_r  <= kid_r;
            kid_r   <= left_move[SLOT_W-1:0];
            state_r <= deeper_ok ? S_PICK : S_FINAL;
          end else begin
            res_slot_r <= hole_r;
            state_r    <= S_EMIT;
          end
        end
        S_FINAL: begin
          res_slot_r <= hole_r;
          state_r    <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_name_r   <= res_name_r;
            out_pay_r    <= res_pay_r;
            out_slot_r   <= res_slot_r;
            out_status_r <= res_status_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.read_name    = NAME_W'(out_name_r);
  assign out_chan.read_payload = PAY_W'(out_pay_r);
  assign out_chan.settled_slot = out_slot_r;
  assign out_chan.status       = out_status_r;

  // While walking the heap, the candidate child lies strictly below the hole
  // and never past the heap end.
  `HSD_ASSERT_SAME(a_kid_in_heap, clk, rst_n, (state_r == S_PICK || state_r == S_MOVE), (hole_r < kid_r && kid_r <= last_r), "sift child outside heap range")

  // The candidate is always a direct child of the hole.
  `HSD_ASSERT_SAME(a_kid_of_hole, clk, rst_n, (state_r == S_PICK || state_r == S_MOVE), ({1'b0, kid_r[SLOT_W-1:1]} == hole_r), "sift child is not a child of the hole")

  // Memory writes come only from a write request or the sift write-back.
  `HSD_ASSERT_SAME(a_write_source, clk, rst_n, mem_we, (state_r == S_IDLE || state_r == S_MOVE || state_r == S_FINAL), "memory write outside a writing state")

  // A result appears only when the emit state hands it over.
  `HSD_ASSERT_NEXT(a_emit_only, clk, rst_n, (!out_valid_r && state_r != S_EMIT), !out_valid_r, "result raised outside the emit state")

endmodule

`default_nettype wire

@@ sv/hsd_store.sv @@
`default_nettype none

// Entry memory: one write port and two read ports, read data registered.
module hsd_store #(
  parameter int AW = 8,
  parameter int EW = 80
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [EW-1:0] rdata_a,
  output logic [EW-1:0] rdata_b
);

  logic [EW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire
